[rtl/core/cfr7_pkg.sv]
// Shared types, codes and constants of the 7-bit command frame receiver.
`timescale 1ns / 1ps

package cfr7_pkg;

    localparam int MaxFrameBytesDefault = 64;
    localparam logic [16:0] ElapsedMax = 17'h1FFFF;
    localparam logic [7:0] CmdBit = 8'h80;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_POLL = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_FRAME_END = 3'd1,
        KIND_SEND = 3'd2,
        KIND_START = 3'd3,
        KIND_STOP = 3'd4,
        KIND_EXECUTE = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        REG_TIMEOUT = 3'd0,
        REG_PING = 3'd1,
        REG_START = 3'd2,
        REG_EXIT = 3'd3,
        REG_READY = 3'd4,
        REG_EXECUTE = 3'd5,
        REG_UPDATE = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ID = 2'd1,
        PH_LEN = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [7:0] code_ping;
        logic [7:0] code_start;
        logic [7:0] code_exit;
        logic [7:0] code_ready;
        logic [7:0] code_execute;
        logic [7:0] code_update;
    } t_cfg;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [6:0] frame_id;
        logic last;
    } t_result;

    typedef struct packed {
        t_result [2:0] res;
        logic [1:0] cnt;
    } t_step;

endpackage

[rtl/core/cfr7_if.sv]
// Channel interfaces of the 7-bit command frame receiver.
`timescale 1ns / 1ps

interface cfr7_in_if;
    logic valid;
    logic ready;
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface cfr7_out_if;
    logic valid;
    logic ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic [6:0] frame_id;
    logic last;
    modport source (output valid, output kind, output value, output frame_id, output last,
                    input ready);
    modport sink (input valid, input kind, input value, input frame_id, input last,
                  output ready);
endinterface

interface cfr7_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/cfr7_cfg.sv]
// Configuration register bank of the 7-bit command frame receiver.
`timescale 1ns / 1ps

module cfr7_cfg
    import cfr7_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  logic [2:0] i_index,
    input  logic [15:0] i_data,
    output t_cfg o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms <= 16'd5000;
            r_cfg.code_ping <= 8'd128;
            r_cfg.code_start <= 8'd129;
            r_cfg.code_exit <= 8'd130;
            r_cfg.code_ready <= 8'd131;
            r_cfg.code_execute <= 8'd132;
            r_cfg.code_update <= 8'd133;
        end else if (i_wr) begin
            unique case (i_index)
                REG_TIMEOUT: r_cfg.timeout_ms <= i_data;
                REG_PING: r_cfg.code_ping <= i_data[7:0];
                REG_START: r_cfg.code_start <= i_data[7:0];
                REG_EXIT: r_cfg.code_exit <= i_data[7:0];
                REG_READY: r_cfg.code_ready <= i_data[7:0];
                REG_EXECUTE: r_cfg.code_execute <= i_data[7:0];
                REG_UPDATE: r_cfg.code_update <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/cfr7_core.sv]
// Parser, unpacker, timeout and handshake state with the per-word step logic.
`timescale 1ns / 1ps

module cfr7_core
    import cfr7_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MaxFrameBytesDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_rx_byte,
    input  t_cfg i_cfg,
    output t_step o_step
);

    localparam logic [7:0] MaxLen = 8'(MAX_FRAME_BYTES);

    t_phase r_phase, n_phase;
    logic [6:0] r_id, n_id;
    logic [6:0] r_len, n_len;
    logic [6:0] r_raw, n_raw;
    logic [3:0] r_bp, n_bp;
    logic [7:0] r_carry, n_carry;
    logic [6:0] r_dec, n_dec;
    logic r_conn, n_conn;
    logic r_rdy, n_rdy;
    logic [16:0] r_elapsed, n_elapsed;

    t_result [2:0] res;
    logic [1:0] cnt;
    logic do_reset;
    logic [3:0] sh;
    logic [7:0] b;

    always_comb begin
        n_phase = r_phase;
        n_id = r_id;
        n_len = r_len;
        n_raw = r_raw;
        n_bp = r_bp;
        n_carry = r_carry;
        n_dec = r_dec;
        n_conn = r_conn;
        n_rdy = r_rdy;
        n_elapsed = r_elapsed;
        res = '0;
        cnt = 2'd0;
        do_reset = 1'b0;
        b = i_rx_byte;
        sh = 4'd8 - r_bp;

        case (i_cmd)
            CMD_BYTE: begin
                if ((b & CmdBit) != 8'd0) begin
                    priority if (b == i_cfg.code_ping) begin
                        res[cnt] = '{KIND_SEND, i_cfg.code_ping, 7'd0, 1'b0};
                        cnt = cnt + 2'd1;
                    end else if (b == i_cfg.code_start) begin
                        n_conn = 1'b1;
                        n_elapsed = '0;
                        res[cnt] = '{KIND_START, 8'd0, 7'd0, 1'b0};
                        cnt = cnt + 2'd1;
                        res[cnt] = '{KIND_SEND, i_cfg.code_ready, 7'd0, 1'b0};
                        cnt = cnt + 2'd1;
                    end else if (b == i_cfg.code_exit) begin
                        n_conn = 1'b0;
                        res[cnt] = '{KIND_STOP, 8'd0, 7'd0, 1'b0};
                        cnt = cnt + 2'd1;
                    end else if (b == i_cfg.code_ready) begin
                        n_rdy = 1'b1;
                        n_elapsed = '0;
                    end else if (b == i_cfg.code_execute) begin
                        if (r_phase != PH_IDLE) begin
                            res[cnt] = '{KIND_EXECUTE, 8'd0, 7'd0, 1'b0};
                            cnt = cnt + 2'd1;
                            n_phase = PH_IDLE;
                        end
                    end else begin
                    end
                    if (b == i_cfg.code_update) begin
                        n_phase = PH_ID;
                    end else begin
                        do_reset = 1'b1;
                    end
                end else begin
                    unique case (r_phase)
                        PH_ID: begin
                            n_id = b[6:0];
                            n_phase = PH_LEN;
                        end
                        PH_LEN: begin
                            if (b > MaxLen) begin
                                do_reset = 1'b1;
                            end else begin
                                n_len = b[6:0];
                                n_raw = '0;
                                n_dec = '0;
                                n_bp = 4'd1;
                                n_carry = '0;
                                n_phase = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            if (r_raw < r_len) begin
                                priority if (r_bp <= 4'd1) begin
                                    n_carry = b << 1;
                                    n_bp = 4'd2;
                                end else if (r_bp >= 4'd8) begin
                                    res[cnt] = '{KIND_PAYLOAD, r_carry | b, r_id, 1'b0};
                                    cnt = cnt + 2'd1;
                                    n_dec = r_dec + 7'd1;
                                    n_carry = '0;
                                    n_bp = 4'd1;
                                end else begin
                                    res[cnt] = '{KIND_PAYLOAD, r_carry | (b >> sh), r_id,
                                                 1'b0};
                                    cnt = cnt + 2'd1;
                                    n_dec = r_dec + 7'd1;
                                    n_carry = b << r_bp;
                                    n_bp = r_bp + 4'd1;
                                end
                                n_raw = r_raw + 7'd1;
                            end
                            if (n_raw >= r_len) begin
                                res[cnt] = '{KIND_FRAME_END, {1'b0, n_dec}, r_id, 1'b0};
                                cnt = cnt + 2'd1;
                                n_raw = '0;
                                n_dec = '0;
                                n_bp = 4'd1;
                                n_carry = '0;
                                n_phase = PH_ID;
                            end
                        end
                        default: do_reset = 1'b1;
                    endcase
                end
                // Parser reset always comes after any result of the word itself.
                if (do_reset) begin
                    if (n_phase != PH_IDLE) begin
                        res[cnt] = '{KIND_SEND, i_cfg.code_ready, 7'd0, 1'b0};
                        cnt = cnt + 2'd1;
                    end
                    n_phase = PH_IDLE;
                    n_len = '0;
                    n_raw = '0;
                    n_dec = '0;
                    n_bp = 4'd1;
                    n_carry = '0;
                end
            end
            CMD_TICK: begin
                if (r_elapsed != ElapsedMax) begin
                    n_elapsed = r_elapsed + 17'd1;
                end
                if (r_conn && (n_elapsed > {1'b0, i_cfg.timeout_ms})) begin
                    n_conn = 1'b0;
                    res[cnt] = '{KIND_STOP, 8'd0, 7'd0, 1'b0};
                    cnt = cnt + 2'd1;
                end
            end
            CMD_POLL: begin
                if (r_rdy) begin
                    res[0] = '{KIND_SEND, i_cfg.code_update, 7'd0, 1'b0};
                    res[1] = '{KIND_SEND, i_cfg.code_execute, 7'd0, 1'b0};
                    res[2] = '{KIND_SEND, i_cfg.code_ready, 7'd0, 1'b0};
                    cnt = 2'd3;
                    n_rdy = 1'b0;
                end
            end
            default: ;
        endcase

        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_id <= '0;
            r_len <= '0;
            r_raw <= '0;
            r_bp <= 4'd1;
            r_carry <= '0;
            r_dec <= '0;
            r_conn <= 1'b0;
            r_rdy <= 1'b0;
            r_elapsed <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_id <= n_id;
            r_len <= n_len;
            r_raw <= n_raw;
            r_bp <= n_bp;
            r_carry <= n_carry;
            r_dec <= n_dec;
            r_conn <= n_conn;
            r_rdy <= n_rdy;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_step.res = res;
    assign o_step.cnt = cnt;

endmodule

[rtl/core/cfr7_outq.sv]
// Three-entry result register that hands out one word per cycle while the reader takes them.
`timescale 1ns / 1ps

module cfr7_outq
    import cfr7_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_step i_step,
    input  logic i_pop,
    output logic o_space,
    output logic o_valid,
    output t_result o_head
);

    t_result [2:0] r_q;
    logic [1:0] r_cnt;

    // A new step fits once the queue is empty or its last word leaves now.
    assign o_space = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_pop);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head = r_q[0];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q <= i_step.res;
        end else if (i_pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push) begin
            r_cnt <= i_step.cnt;
        end else if (i_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

[rtl/core/command_frame_receiver_7bit_top.sv]
// Top level of the 7-bit command frame receiver.
`timescale 1ns / 1ps

// Serial command frame receiver. Each input word carries either a received byte, a
// one millisecond tick or a poll; the block answers with zero to three result words,
// the final one of a word's results marked by last. Command bytes (bit 7 set) run the
// session: ping is echoed, start connects and sends ready, exit disconnects, ready
// marks the handshake and restarts the timeout, execute closes an open update, and
// update opens frames of id, length and 7-bit packed data, which are unpacked into
// 8-bit payload words followed by a frame-end word with the decoded count. Any other
// command, a stray data byte or an oversize length resets the parser and sends ready
// if a frame sequence was open. Ticks age a saturating counter that drops the
// connection once more than timeout_ms ticks have passed; a poll with the ready mark
// set sends update, execute and ready. One word's work is done combinationally on
// acceptance; its results load into a three-entry result register that delivers one
// word per cycle while the output is ready. A new word waits until the previous
// word's results are gone or leaving, so a word is taken every cycle while each
// causes at most one result and the output is ready. The configuration channel is
// always ready; write it only while no results are pending. Reset is synchronous.

module command_frame_receiver_7bit_top
    import cfr7_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MaxFrameBytesDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cfr7_in_if.sink i_in,
    cfr7_out_if.source o_out,
    cfr7_cfg_if.sink i_cfg
);

    t_cfg cfg;
    t_step step;
    t_result head;
    logic accept;
    logic pop;
    logic space;
    logic out_valid;

    // Configuration writes are taken at once.
    assign i_cfg.ready = 1'b1;

    cfr7_cfg u_cfg (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_wr(i_cfg.valid),
        .i_index(i_cfg.index),
        .i_data(i_cfg.data),
        .o_cfg(cfg)
    );

    assign i_in.ready = space;
    assign accept = i_in.valid && space;

    cfr7_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_core (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_accept(accept),
        .i_cmd(i_in.cmd),
        .i_rx_byte(i_in.rx_byte),
        .i_cfg(cfg),
        .o_step(step)
    );

    assign pop = out_valid && o_out.ready;

    cfr7_outq u_outq (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(accept),
        .i_step(step),
        .i_pop(pop),
        .o_space(space),
        .o_valid(out_valid),
        .o_head(head)
    );

    assign o_out.valid = out_valid;
    assign o_out.kind = head.kind;
    assign o_out.value = head.value;
    assign o_out.frame_id = head.frame_id;
    assign o_out.last = head.last;

endmodule

[tb/tb_command_frame_receiver_7bit_top.sv]
// Testbench for the 7-bit command frame receiver, checked against a predictor.
`timescale 1ns / 1ps

// The testbench drives input words from a queue through a clocked driver. A clocked
// monitor does three things at each rising edge:
//   - it mirrors accepted configuration writes into its own copy of the settings;
//   - it runs every accepted input word through a predictor that keeps its own parser,
//     session and timeout state, and appends the predicted result words to a queue;
//   - it compares every accepted result word field by field with the oldest prediction.
// The stimulus starts with a short directed part that touches every command, the zero
// length frame, the oversize length, a stray data byte, update while a frame sequence is
// open and the unused command value. Random sessions follow, each under its own register
// settings. The settings include the timeout extremes, overlapping command codes and a
// code below 128. Registers are only rewritten once every predicted word has arrived.
// One or both sides stall in random bursts, but the last session runs at full rate.

module tb_command_frame_receiver_7bit_top;
    import cfr7_pkg::*;

    localparam int FrameMax = MaxFrameBytesDefault;
    localparam int SettleCycles = 4;
    localparam logic [1:0] CmdUnused = 2'd3;
    localparam t_cfg CfgReset = '{
        timeout_ms: 16'd5000,
        code_ping: 8'd128,
        code_start: 8'd129,
        code_exit: 8'd130,
        code_ready: 8'd131,
        code_execute: 8'd132,
        code_update: 8'd133
    };

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } t_link_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Signals that the testbench owns; the interfaces follow them continuously, so every
    // input of the block has a known value from time zero.
    logic src_valid = 1'b0;
    logic [1:0] src_cmd = '0;
    logic [7:0] src_byte = '0;
    logic snk_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    cfr7_in_if rx_if ();
    cfr7_out_if rep_if ();
    cfr7_cfg_if cfg_if ();

    assign rx_if.valid = src_valid;
    assign rx_if.cmd = src_cmd;
    assign rx_if.rx_byte = src_byte;
    assign rep_if.ready = snk_ready;
    assign cfg_if.valid = cfg_valid;
    assign cfg_if.index = cfg_index;
    assign cfg_if.data = cfg_data;

    command_frame_receiver_7bit_top #(
        .MAX_FRAME_BYTES(FrameMax)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(rx_if),
        .o_out(rep_if),
        .i_cfg(cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // Words waiting to be driven, and result words predicted but not yet seen.
    t_link_word link_words[$];
    t_result reply_queue[$];
    t_result step_replies[$];
    int words_queued = 0;
    int mismatch_count = 0;

    // Stall control. Percent chance that a burst starts after a sent word or a ready cycle.
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int src_gap = 0;
    int snk_gap = 0;

    // Predictor state: settings, parser, session and timeout.
    t_cfg cfg_now;
    t_phase rx_phase;
    logic [6:0] frame_id_q;
    logic [6:0] frame_len;
    logic [6:0] raw_seen;
    logic [3:0] bit_pos;
    logic [7:0] carry;
    logic [6:0] decoded;
    logic link_up;
    logic ready_mark;
    logic [16:0] tick_age;

    // The block sends at most three result words per input word; anything beyond is lost.
    function automatic void add_reply(t_kind kind, logic [7:0] value, logic [6:0] fid);
        t_result r;
        if (step_replies.size() < 3) begin
            r.kind = kind;
            r.value = value;
            r.frame_id = fid;
            r.last = 1'b0;
            step_replies.push_back(r);
        end
    endfunction

    function automatic void restart_frame();
        raw_seen = '0;
        decoded = '0;
        bit_pos = 4'd1;
        carry = '0;
    endfunction

    // Leaving an open frame sequence tells the host that the receiver is ready again.
    function automatic void drop_parse();
        if (rx_phase != PH_IDLE) add_reply(KIND_SEND, cfg_now.code_ready, '0);
        rx_phase = PH_IDLE;
        frame_len = '0;
        restart_frame();
    endfunction

    // Seven data bits arrive per byte; a full output byte is ready from the second byte
    // of each group of eight on, and the eighth byte completes one with no carry left.
    function automatic void unpack_data(logic [7:0] b);
        logic [7:0] outb;
        if (bit_pos <= 4'd1) begin
            carry = b << 1;
            bit_pos = 4'd2;
        end else if (bit_pos >= 4'd8) begin
            outb = carry | b;
            add_reply(KIND_PAYLOAD, outb, frame_id_q);
            decoded = decoded + 7'd1;
            carry = '0;
            bit_pos = 4'd1;
        end else begin
            outb = carry | (b >> (8 - bit_pos));
            add_reply(KIND_PAYLOAD, outb, frame_id_q);
            decoded = decoded + 7'd1;
            carry = b << bit_pos;
            bit_pos = bit_pos + 4'd1;
        end
    endfunction

    function automatic void take_byte(logic [7:0] b);
        if (b[7]) begin
            // The first matching code acts; update is checked on its own afterward.
            if (b == cfg_now.code_ping) begin
                add_reply(KIND_SEND, cfg_now.code_ping, '0);
            end else if (b == cfg_now.code_start) begin
                link_up = 1'b1;
                tick_age = '0;
                add_reply(KIND_START, '0, '0);
                add_reply(KIND_SEND, cfg_now.code_ready, '0);
            end else if (b == cfg_now.code_exit) begin
                link_up = 1'b0;
                add_reply(KIND_STOP, '0, '0);
            end else if (b == cfg_now.code_ready) begin
                ready_mark = 1'b1;
                tick_age = '0;
            end else if (b == cfg_now.code_execute) begin
                if (rx_phase != PH_IDLE) begin
                    add_reply(KIND_EXECUTE, '0, '0);
                    rx_phase = PH_IDLE;
                end
            end
            if (b == cfg_now.code_update) rx_phase = PH_ID;
            else drop_parse();
        end else begin
            case (rx_phase)
                PH_ID: begin
                    frame_id_q = b[6:0];
                    rx_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (b > FrameMax) begin
                        drop_parse();
                    end else begin
                        frame_len = b[6:0];
                        restart_frame();
                        rx_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    // A zero length frame still swallows one byte before it ends.
                    if (raw_seen < frame_len) begin
                        unpack_data(b);
                        raw_seen = raw_seen + 7'd1;
                    end
                    if (raw_seen >= frame_len) begin
                        add_reply(KIND_FRAME_END, {1'b0, decoded}, frame_id_q);
                        restart_frame();
                        rx_phase = PH_ID;
                    end
                end
                default: drop_parse();
            endcase
        end
    endfunction

    function automatic void compute_replies(logic [1:0] cmd, logic [7:0] b);
        int n;
        step_replies.delete();
        case (cmd)
            CMD_BYTE: take_byte(b);
            CMD_TICK: begin
                if (tick_age < ElapsedMax) tick_age = tick_age + 17'd1;
                if (link_up && tick_age > {1'b0, cfg_now.timeout_ms}) begin
                    link_up = 1'b0;
                    add_reply(KIND_STOP, '0, '0);
                end
            end
            CMD_POLL: begin
                if (ready_mark) begin
                    add_reply(KIND_SEND, cfg_now.code_update, '0);
                    add_reply(KIND_SEND, cfg_now.code_execute, '0);
                    add_reply(KIND_SEND, cfg_now.code_ready, '0);
                    ready_mark = 1'b0;
                end
            end
            default: ;
        endcase
        n = step_replies.size();
        for (int i = 0; i < n; i++) begin
            step_replies[i].last = (i == n - 1);
            reply_queue.push_back(step_replies[i]);
        end
    endfunction

    function automatic void reset_receiver_model();
        cfg_now = CfgReset;
        rx_phase = PH_IDLE;
        frame_id_q = '0;
        frame_len = '0;
        restart_frame();
        link_up = 1'b0;
        ready_mark = 1'b0;
        tick_age = '0;
        reply_queue.delete();
    endfunction

    function automatic void apply_setting(logic [2:0] idx, logic [15:0] data);
        case (idx)
            REG_TIMEOUT: cfg_now.timeout_ms = data;
            REG_PING: cfg_now.code_ping = data[7:0];
            REG_START: cfg_now.code_start = data[7:0];
            REG_EXIT: cfg_now.code_exit = data[7:0];
            REG_READY: cfg_now.code_ready = data[7:0];
            REG_EXECUTE: cfg_now.code_execute = data[7:0];
            REG_UPDATE: cfg_now.code_update = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Driver: a new word goes out whenever the current one has been taken, unless an
    // idle burst is running. valid stays high across back-to-back words.
    always @(posedge i_clk) begin : drive_words
        t_link_word w;
        if (!i_rst_n) begin
            src_valid <= 1'b0;
            src_gap = 0;
        end else if (!src_valid || rx_if.ready) begin
            if (src_gap > 0) begin
                src_valid <= 1'b0;
                src_gap--;
            end else if (link_words.size() > 0) begin
                w = link_words.pop_front();
                src_valid <= 1'b1;
                src_cmd <= w.cmd;
                src_byte <= w.rx_byte;
                if ($urandom_range(0, 99) < src_idle_pct) src_gap = $urandom_range(1, 9);
            end else begin
                src_valid <= 1'b0;
            end
        end
    end

    // Monitor: settings first, then prediction, then the check. A result word never
    // leaves in the cycle its input word is taken, so this order is safe.
    always @(posedge i_clk) begin : watch_replies
        t_result want;
        if (!i_rst_n) begin
            reset_receiver_model();
            snk_ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (cfg_valid && cfg_if.ready) apply_setting(cfg_index, cfg_data);
            if (src_valid && rx_if.ready) compute_replies(src_cmd, src_byte);
            if (rep_if.valid && snk_ready) begin
                if (reply_queue.size() == 0) begin
                    $error("result word with nothing predicted: kind %0d value %0d",
                           rep_if.kind, rep_if.value);
                    mismatch_count++;
                end else begin
                    want = reply_queue.pop_front();
                    check_field("kind", want.kind, rep_if.kind);
                    check_field("value", want.value, rep_if.value);
                    check_field("frame_id", want.frame_id, rep_if.frame_id);
                    check_field("last", want.last, rep_if.last);
                end
            end
            if (snk_gap > 0) begin
                snk_ready <= 1'b0;
                snk_gap--;
            end else begin
                snk_ready <= 1'b1;
                if ($urandom_range(0, 99) < snk_idle_pct) snk_gap = $urandom_range(1, 9);
            end
        end
    end

    function automatic void push_word(logic [1:0] cmd, logic [7:0] b);
        t_link_word w;
        w.cmd = cmd;
        w.rx_byte = b;
        link_words.push_back(w);
        words_queued++;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        push_word(CMD_BYTE, b);
    endfunction

    // One of the current command codes, or some other byte with bit 7 set.
    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 6))
            0: return cfg_now.code_ping;
            1: return cfg_now.code_start;
            2: return cfg_now.code_exit;
            3: return cfg_now.code_ready;
            4: return cfg_now.code_execute;
            5: return cfg_now.code_update;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    // A well-formed update batch with random content: mostly short frames, now and then
    // a full-size one, rarely an oversize length or a command that cuts a frame short.
    task automatic queue_update_run();
        int frames;
        int len;
        int span;
        int sel;
        push_byte(cfg_now.code_update);
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++) begin
            push_byte(8'($urandom_range(0, 127)));
            sel = $urandom_range(0, 99);
            if (sel < 80) len = $urandom_range(0, 6);
            else if (sel < 94) len = $urandom_range(7, 16);
            else if (sel < 97) len = FrameMax;
            else len = $urandom_range(FrameMax + 1, 127);
            push_byte(8'(len));
            if (len > FrameMax) return;
            span = (len == 0) ? 1 : len;
            for (int k = 0; k < span; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 2) begin
                    push_byte(pick_command());
                    return;
                end
                if (sel < 6) push_word(CMD_TICK, 8'($urandom));
                push_byte(8'($urandom_range(0, 127)));
            end
        end
        if ($urandom_range(0, 99) < 70) push_byte(cfg_now.code_execute);
    endtask

    task automatic queue_traffic(int n);
        int stop_at;
        int sel;
        stop_at = words_queued + n;
        while (words_queued < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                queue_update_run();
            end else if (sel < 67) begin
                push_byte(pick_command());
            end else if (sel < 77) begin
                repeat ($urandom_range(1, 4)) push_word(CMD_TICK, 8'($urandom));
            end else if (sel < 85) begin
                push_byte(cfg_now.code_ready);
                push_word(CMD_POLL, 8'($urandom));
            end else if (sel < 90) begin
                push_word(CMD_POLL, 8'($urandom));
            end else if (sel < 95) begin
                push_byte(8'($urandom));
            end else begin
                push_word(CmdUnused, 8'($urandom));
            end
        end
    endtask

    // Returns on a falling edge once nothing is queued, in flight or predicted, plus a
    // settling wait for a word that was taken without causing any result.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (link_words.size() != 0 || src_valid || reply_queue.size() != 0);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // Writes all seven registers back to back; the code registers get junk in the
    // unused upper byte.
    task automatic load_settings(t_cfg c);
        logic [15:0] vals [7];
        vals[0] = c.timeout_ms;
        vals[1] = {8'($urandom), c.code_ping};
        vals[2] = {8'($urandom), c.code_start};
        vals[3] = {8'($urandom), c.code_exit};
        vals[4] = {8'($urandom), c.code_ready};
        vals[5] = {8'($urandom), c.code_execute};
        vals[6] = {8'($urandom), c.code_update};
        @(posedge i_clk);
        for (int i = 0; i < 7; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(t_reg_idx'(i));
            cfg_data <= vals[i];
            do @(posedge i_clk);
            while (!cfg_if.ready);
        end
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : run_sessions
        t_cfg c;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words under the reset settings.
        src_idle_pct = 25;
        snk_idle_pct = 25;
        push_byte(cfg_now.code_ping);           // echoed back
        push_byte(cfg_now.code_start);          // start word, then ready is sent
        push_byte(cfg_now.code_ready);          // sets the ready mark, no result
        push_word(CMD_POLL, 8'hFF);             // handshake: update, execute, ready
        push_word(CMD_POLL, 8'h00);             // mark already cleared: nothing
        push_byte(8'h00);                       // stray data byte while idle
        push_byte(cfg_now.code_update);
        push_byte(8'h7F);                       // frame id at its top value
        push_byte(8'd3);
        push_byte(8'h7F);
        push_byte(8'h00);
        push_byte(8'h55);
        push_byte(8'h00);                       // next frame, id zero
        push_byte(8'd0);                        // zero length eats one more byte
        push_byte(8'h7F);
        push_byte(cfg_now.code_update);         // update while a sequence is open
        push_byte(8'h12);
        push_byte(8'd65);                       // one past the largest frame
        push_byte(cfg_now.code_update);
        push_byte(cfg_now.code_execute);        // closes the open update
        push_byte(8'hFF);                       // unknown command while idle
        push_byte(cfg_now.code_update);
        push_byte(8'hFF);                       // unknown command with a sequence open
        push_byte(cfg_now.code_exit);
        push_word(CmdUnused, 8'hAA);            // ignored
        push_word(CMD_TICK, 8'h55);             // not connected, so no stop
        // Hold the sender until every predicted word has been seen.
        wait_drained();
        queue_traffic(60);
        wait_drained();

        // Zero timeout: the first tick after start drops the connection. Codes sit at
        // both ends of the command range. Only the receiver stalls here.
        c = CfgReset;
        c.timeout_ms = 16'd0;
        c.code_ping = 8'hFF;
        c.code_start = 8'h80;
        c.code_exit = 8'h90;
        c.code_ready = 8'hC0;
        c.code_execute = 8'hA5;
        c.code_update = 8'hFE;
        load_settings(c);
        src_idle_pct = 0;
        snk_idle_pct = 40;
        push_byte(cfg_now.code_start);
        push_word(CMD_TICK, 8'h00);
        queue_traffic(70);
        wait_drained();

        // Longest timeout, and overlapping codes: update shares its code with start,
        // execute shares one with ready, and exit sits below 128 so it is only data.
        c.timeout_ms = 16'hFFFF;
        c.code_ping = 8'h80;
        c.code_start = 8'h9A;
        c.code_exit = 8'h05;
        c.code_ready = 8'hB3;
        c.code_execute = 8'hB3;
        c.code_update = 8'h9A;
        load_settings(c);
        src_idle_pct = 40;
        snk_idle_pct = 0;
        queue_traffic(70);
        wait_drained();

        // Short random timeout and random codes, which may collide.
        c.timeout_ms = 16'($urandom_range(1, 12));
        c.code_ping = 8'($urandom_range(128, 255));
        c.code_start = 8'($urandom_range(128, 255));
        c.code_exit = 8'($urandom_range(128, 255));
        c.code_ready = 8'($urandom_range(128, 255));
        c.code_execute = 8'($urandom_range(128, 255));
        c.code_update = 8'($urandom_range(128, 255));
        load_settings(c);
        src_idle_pct = 15;
        snk_idle_pct = 15;
        queue_traffic(70);
        wait_drained();

        // Back to the reset codes with a short timeout, at full rate on both sides.
        c = CfgReset;
        c.timeout_ms = 16'd3;
        load_settings(c);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_traffic(60);
        wait_drained();

        if (mismatch_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
